### src/mop_pkg.sv
// ----------------------------------------------------------------------------
// mop_pkg
// Shared types and constants for the Markov occupancy propagator.
// ----------------------------------------------------------------------------
package mop_pkg;

	localparam int          MAX_STATES = 8;

	localparam logic [15:0] ONE_Q15    = 16'd32768;
	localparam int          ROUND_HALF = 16384;

	// configuration register indexes
	localparam logic REG_NUM_STATES   = 1'b0;
	localparam logic REG_DENSITY      = 1'b1;

	localparam logic MODE_INIT = 1'b0;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL,
		ST_ACC,
		ST_CRD,
		ST_CWR,
		ST_ERD,
		ST_EMUL,
		ST_EOUT
	} ctl_state_t;

	typedef struct packed {
		logic cap;       // latch input item
		logic init_wr;   // write initial vector element
		logic rd_item;   // read dist[row] and accum[col]
		logic mul;       // dist * p
		logic acc_wr;    // accumulate into accum[col]
		logic k_clr;
		logic k_inc;
		logic crd;       // read accum[k]
		logic cwr;       // commit accum[k] into dist[k]
		logic acc_clear;
		logic occ_zero;
		logic occ_inc;
		logic erd;       // read dist[1]
		logic emul;      // density * dist[1]
		logic out_load;
	} mop_cmd_t;

	typedef struct packed {
		logic mode;
		logic in_range;
		logic last_load;
		logic last_mat;
		logic k_last;
		logic out_free;
	} mop_sts_t;

endpackage

### src/mop_ctrl.sv
// ----------------------------------------------------------------------------
// mop_ctrl
// Sequencer: walks one item at a time through check, load or accumulate, commit and emit.
// ----------------------------------------------------------------------------
module mop_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  mop_pkg::mop_sts_t sts,
	output mop_pkg::mop_cmd_t cmd
);

	mop_pkg::ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mop_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			mop_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.cap = 1'b1;
					state_d = mop_pkg::ST_CHECK;
				end
			end
			mop_pkg::ST_CHECK: begin
				if (!sts.in_range) begin
					state_d = mop_pkg::ST_IDLE;
				end else if (sts.mode == mop_pkg::MODE_INIT) begin
					cmd.init_wr = 1'b1;
					if (sts.last_load) begin
						cmd.acc_clear = 1'b1;
						cmd.occ_zero  = 1'b1;
						state_d       = mop_pkg::ST_ERD;
					end else begin
						state_d = mop_pkg::ST_IDLE;
					end
				end else begin
					cmd.rd_item = 1'b1;
					state_d     = mop_pkg::ST_MUL;
				end
			end
			mop_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = mop_pkg::ST_ACC;
			end
			mop_pkg::ST_ACC: begin
				cmd.acc_wr = 1'b1;
				if (sts.last_mat) begin
					cmd.k_clr = 1'b1;
					state_d   = mop_pkg::ST_CRD;
				end else begin
					state_d = mop_pkg::ST_IDLE;
				end
			end
			mop_pkg::ST_CRD: begin
				cmd.crd = 1'b1;
				state_d = mop_pkg::ST_CWR;
			end
			mop_pkg::ST_CWR: begin
				cmd.cwr = 1'b1;
				if (sts.k_last) begin
					cmd.acc_clear = 1'b1;
					cmd.occ_inc   = 1'b1;
					state_d       = mop_pkg::ST_ERD;
				end else begin
					cmd.k_inc = 1'b1;
					state_d   = mop_pkg::ST_CRD;
				end
			end
			mop_pkg::ST_ERD: begin
				cmd.erd = 1'b1;
				state_d = mop_pkg::ST_EMUL;
			end
			mop_pkg::ST_EMUL: begin
				cmd.emul = 1'b1;
				state_d  = mop_pkg::ST_EOUT;
			end
			mop_pkg::ST_EOUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = mop_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mop_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### src/mop_datapath.sv
// ----------------------------------------------------------------------------
// mop_datapath
// Config registers, distribution and accumulator stores, multipliers,
// occasion counter and output register.
// ----------------------------------------------------------------------------
module mop_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic              wr_index,
	input  logic [31:0]       wr_data,
	input  logic              mode,
	input  logic [2:0]        row_index,
	input  logic [2:0]        col_index,
	input  logic [15:0]       prob_value,
	input  mop_pkg::mop_cmd_t cmd,
	output mop_pkg::mop_sts_t sts,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [15:0]       occasion,
	output logic [31:0]       mean_density
);

	localparam int IDX_W = (mop_pkg::MAX_STATES > 2) ? $clog2(mop_pkg::MAX_STATES) : 1;

	logic [3:0]  num_states_q;
	logic [31:0] density_q;

	logic        it_mode_q;
	logic [2:0]  it_row_q, it_col_q;
	logic [15:0] it_p_q;
	logic [3:0]  it_n_q;
	logic [3:0]  n_cfg;
	logic [15:0] p_sat;

	logic [15:0] cur_mem [mop_pkg::MAX_STATES];
	logic [33:0] acc_mem [mop_pkg::MAX_STATES];
	logic [mop_pkg::MAX_STATES-1:0] acc_vld_q;
	logic [15:0] cur_rd_q;
	logic [33:0] acc_rd_q;
	logic        acc_rv_q;
	logic [31:0] prod_q;
	logic [47:0] mprod_q;
	logic [3:0]  k_q;
	logic [15:0] occ_q;
	logic        out_valid_q;
	logic [15:0] out_occ_q;
	logic [31:0] out_mean_q;

	logic [IDX_W-1:0] row_idx, col_idx, k_idx, cur_ra, cur_wa, acc_ra;
	logic             cur_we, cur_re, acc_re;
	logic [15:0]      cur_wd, commit_val;
	logic [33:0]      acc_old, acc_new;
	logic [34:0]      acc_sum, acc_rnd;
	logic [48:0]      mean_rnd;
	logic [31:0]      mean_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_states_q <= 4'd2;
			density_q    <= 32'd65536;
		end else if (wr_en) begin
			case (wr_index)
				mop_pkg::REG_NUM_STATES: num_states_q <= wr_data[3:0];
				mop_pkg::REG_DENSITY:    density_q    <= wr_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (num_states_q < 4'd2)
			n_cfg = 4'd2;
		else if (32'(num_states_q) > mop_pkg::MAX_STATES)
			n_cfg = 4'(mop_pkg::MAX_STATES);
		else
			n_cfg = num_states_q;
	end

	assign p_sat = (prob_value > mop_pkg::ONE_Q15) ? mop_pkg::ONE_Q15 : prob_value;

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			it_mode_q <= mode;
			it_row_q  <= row_index;
			it_col_q  <= col_index;
			it_p_q    <= p_sat;
			it_n_q    <= n_cfg;
		end
	end

	assign row_idx = IDX_W'(it_row_q);
	assign col_idx = IDX_W'(it_col_q);
	assign k_idx   = IDX_W'(k_q);

	assign sts.mode      = it_mode_q;
	assign sts.in_range  = ({1'b0, it_row_q} < it_n_q) &&
		((it_mode_q == mop_pkg::MODE_INIT) || ({1'b0, it_col_q} < it_n_q));
	assign sts.last_load = ({1'b0, it_row_q} == it_n_q - 4'd1);
	assign sts.last_mat  = sts.last_load && ({1'b0, it_col_q} == it_n_q - 4'd1);
	assign sts.k_last    = (k_q == it_n_q - 4'd1);
	assign sts.out_free  = !out_valid_q || !out_stall;

	// distribution store
	assign cur_re = cmd.rd_item | cmd.erd;
	assign cur_ra = cmd.erd ? IDX_W'(1) : row_idx;
	assign cur_we = cmd.init_wr | cmd.cwr;
	assign cur_wa = cmd.cwr ? k_idx : row_idx;
	assign cur_wd = cmd.cwr ? commit_val : it_p_q;

	always_ff @(posedge clk) begin
		if (cur_we)
			cur_mem[cur_wa] <= cur_wd;
		if (cur_re)
			cur_rd_q <= cur_mem[cur_ra];
	end

	// accumulator store; an entry without its valid bit reads as zero
	assign acc_re  = cmd.rd_item | cmd.crd;
	assign acc_ra  = cmd.crd ? k_idx : col_idx;
	assign acc_old = acc_rv_q ? acc_rd_q : 34'd0;
	assign acc_sum = {1'b0, acc_old} + {3'd0, prod_q};
	assign acc_new = acc_sum[34] ? '1 : acc_sum[33:0];

	always_ff @(posedge clk) begin
		if (cmd.acc_wr)
			acc_mem[col_idx] <= acc_new;
		if (acc_re) begin
			acc_rd_q <= acc_mem[acc_ra];
			acc_rv_q <= acc_vld_q[acc_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_vld_q <= '0;
		end else if (cmd.acc_clear) begin
			acc_vld_q <= '0;
		end else if (cmd.acc_wr) begin
			acc_vld_q[col_idx] <= 1'b1;
		end
	end

	// commit: round half up to Q1.15, saturate at one
	assign acc_rnd    = {1'b0, acc_old} + 35'(mop_pkg::ROUND_HALF);
	assign commit_val = (acc_rnd[34:15] > 20'(mop_pkg::ONE_Q15)) ?
		mop_pkg::ONE_Q15 : acc_rnd[30:15];

	always_ff @(posedge clk) begin
		if (cmd.mul)
			prod_q <= cur_rd_q * it_p_q;
		if (cmd.emul)
			mprod_q <= density_q * cur_rd_q;
	end

	assign mean_rnd = {1'b0, mprod_q} + 49'(mop_pkg::ROUND_HALF);
	assign mean_val = (mean_rnd[48:47] != 2'd0) ? '1 : mean_rnd[46:15];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= 4'd0;
			occ_q       <= 16'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.k_clr)
				k_q <= 4'd0;
			else if (cmd.k_inc)
				k_q <= k_q + 4'd1;
			if (cmd.occ_zero)
				occ_q <= 16'd0;
			else if (cmd.occ_inc && (occ_q != 16'hFFFF))
				occ_q <= occ_q + 16'd1;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_occ_q  <= occ_q;
			out_mean_q <= mean_val;
		end
	end

	assign out_valid    = out_valid_q;
	assign occasion     = out_occ_q;
	assign mean_density = out_mean_q;

endmodule

### src/markov_occupancy_propagator_core.sv
// A result follows the final initial-vector element through check, dist[1] read,
// density multiply and output; a matrix's final element adds multiply, accumulate
// and a commit pass that reads and writes back each state. An out-of-range item
// or non-final load returns to idle after check; other matrix elements return
// after multiply and accumulate. Items are taken only in idle, one at a time.
// Reset clears control, accumulator valid bits and occasion count and sets config to defaults; no clearing pass.
// ----------------------------------------------------------------------------
// markov_occupancy_propagator_core
// Forward propagation of a life-state distribution through streamed matrices.
// ----------------------------------------------------------------------------
module markov_occupancy_propagator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [31:0] wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [2:0]  row_index,
	input  logic [2:0]  col_index,
	input  logic [15:0] prob_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] occasion,
	output logic [31:0] mean_density
);

	mop_pkg::mop_cmd_t cmd;
	mop_pkg::mop_sts_t sts;

	mop_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	mop_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.mode         (mode),
		.row_index    (row_index),
		.col_index    (col_index),
		.prob_value   (prob_value),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.occasion     (occasion),
		.mean_density (mean_density)
	);

	// a result is never loaded over one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || !out_stall))
		else $error("result overwritten before delivery");

	// once an item is taken the block is busy on the next cycle
	a_busy_after_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cap |=> in_stall)
		else $error("item accepted while previous item in work");

	// only one store write source in any cycle
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.init_wr, cmd.cwr, cmd.acc_wr}))
		else $error("conflicting store writes");

	// the occasion count is forced to zero only by an initial load
	a_occ_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.occ_zero |-> cmd.init_wr)
		else $error("occasion cleared outside initial load");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for markov_occupancy_propagator_core. A scoreboard
// class keeps its own copy of the distribution, the accumulators and the
// occasion count. It predicts each mean density and checks the results in
// order. Stimulus is a directed block, then matrices, loads, partial and
// saturating sequences with noise, under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int          N_MAX        = mop_pkg::MAX_STATES;
	localparam logic        MODE_MATRIX  = 1'b1;
	localparam logic [33:0] ACC_LIMIT    = 34'h3_FFFF_FFFF;
	localparam logic [31:0] MEAN_LIMIT   = 32'hFFFF_FFFF;
	localparam int          SETTLE_CYCLES = 40;
	localparam int          ITEMS_PER_PHASE = 140;
	localparam longint      LIMIT_NS     = 64'd20_000_000;

	typedef enum int {
		SEQ_MATRIX,
		SEQ_LOAD,
		SEQ_PARTIAL,
		SEQ_SATURATE,
		SEQ_NOISE
	} seq_kind_t;

	typedef struct {
		logic [15:0] occ;
		logic [31:0] density;
	} density_result_t;

	class occupancy_scoreboard;
		bit [15:0] cur_dist [N_MAX];
		bit [33:0] accum [N_MAX];
		bit [15:0] occ_count;
		bit [3:0]  cfg_states;
		bit [31:0] cfg_density;
		density_result_t density_queue [$];
		int unsigned mismatches;
		int unsigned results_checked;
		int unsigned items_applied;
		int unsigned top_occ;

		function new();
			cfg_states  = 4'd2;
			cfg_density = 32'd65536;
			occ_count   = '0;
			foreach (cur_dist[k]) begin
				cur_dist[k] = '0;
				accum[k]    = '0;
			end
		endfunction

		function void set_reg(logic idx, logic [31:0] val);
			if (idx == mop_pkg::REG_NUM_STATES) begin
				cfg_states = val[3:0];
			end else begin
				cfg_density = val;
			end
		endfunction

		function int unsigned states_used();
			if (cfg_states < 2) begin
				return 2;
			end
			if (cfg_states > N_MAX) begin
				return N_MAX;
			end
			return cfg_states;
		endfunction

		function void queue_density();
			bit [63:0] wide;
			density_result_t res;
			wide = cfg_density;
			wide = wide * cur_dist[1] + mop_pkg::ROUND_HALF;
			wide = wide >> 15;
			res.occ = occ_count;
			res.density = (wide > MEAN_LIMIT) ? MEAN_LIMIT : wide[31:0];
			density_queue.push_back(res);
		endfunction

		function void clear_accum();
			foreach (accum[k]) begin
				accum[k] = '0;
			end
		endfunction

		function void apply_item(logic m, logic [2:0] r, logic [2:0] c, logic [15:0] pv);
			int unsigned n;
			bit [15:0] p;
			bit [63:0] sum;
			bit [63:0] term;
			items_applied++;
			n = states_used();
			p = (pv > mop_pkg::ONE_Q15) ? mop_pkg::ONE_Q15 : pv;
			if (r >= n) begin
				return;
			end
			if (m == mop_pkg::MODE_INIT) begin
				cur_dist[r] = p;
				if (r != n - 1) begin
					return;
				end
				occ_count = '0;
				clear_accum();
				queue_density();
				return;
			end
			if (c >= n) begin
				return;
			end
			term = cur_dist[r];
			term = term * p;
			sum  = accum[c];
			sum  = sum + term;
			accum[c] = (sum > ACC_LIMIT) ? ACC_LIMIT : sum[33:0];
			if (r != n - 1 || c != n - 1) begin
				return;
			end
			// commit: round half up, clamp at one
			for (int k = 0; k < n; k++) begin
				sum = accum[k];
				sum = (sum + mop_pkg::ROUND_HALF) >> 15;
				cur_dist[k] = (sum > mop_pkg::ONE_Q15) ? mop_pkg::ONE_Q15 : sum[15:0];
			end
			clear_accum();
			if (occ_count != 16'hFFFF) begin
				occ_count++;
			end
			queue_density();
		endfunction

		function void report(string msg);
			mismatches++;
			if (mismatches <= 10) begin
				$display("tb_top: %0t: %s", $time, msg);
			end
		endfunction

		function void compare_result(logic [15:0] occ, logic [31:0] dens);
			density_result_t want;
			results_checked++;
			if (density_queue.size() == 0) begin
				report($sformatf("unexpected result: occasion %0d density 0x%08h", occ, dens));
				return;
			end
			want = density_queue.pop_front();
			if (occ > top_occ) begin
				top_occ = occ;
			end
			if (occ !== want.occ) begin
				report($sformatf("occasion: expected %0d, got %0d", want.occ, occ));
			end
			if (dens !== want.density) begin
				report($sformatf("mean_density (occasion %0d): expected 0x%08h, got 0x%08h",
					want.occ, want.density, dens));
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n     = 1'b0;
	logic        wr_en      = 1'b0;
	logic        wr_index   = 1'b0;
	logic [31:0] wr_data    = '0;
	logic        in_valid   = 1'b0;
	logic        in_stall;
	logic        mode       = 1'b0;
	logic [2:0]  row_index  = '0;
	logic [2:0]  col_index  = '0;
	logic [15:0] prob_value = '0;
	logic        out_valid;
	logic        out_stall  = 1'b0;
	logic [15:0] occasion;
	logic [31:0] mean_density;

	occupancy_scoreboard sb = new();
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct     = 0;
	int unsigned items_counted = 0;
	int unsigned reg_writes    = 0;

	markov_occupancy_propagator_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.row_index    (row_index),
		.col_index    (col_index),
		.prob_value   (prob_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.occasion     (occasion),
		.mean_density (mean_density)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(LIMIT_NS);
		$display("tb_top: timeout");
		$display("tb_top: done, errors");
		$finish;
	end

	// result side: sample, then pick next cycle's stall
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			sb.compare_result(occasion, mean_density);
		end
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	function automatic logic [15:0] pick_prob();
		case ($urandom_range(7))
			0: return '0;
			1: return mop_pkg::ONE_Q15;
			2: return 16'($urandom_range(65535, 32769));
			default: return 16'($urandom_range(32768));
		endcase
	endfunction

	task automatic send_item(logic m, logic [2:0] r, logic [2:0] c, logic [15:0] pv);
		int unsigned n;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		mode       <= m;
		row_index  <= r;
		col_index  <= c;
		prob_value <= pv;
		do @(posedge clk); while (in_stall !== 1'b0);
		n = sb.states_used();
		if (r < n && (m == mop_pkg::MODE_INIT || c < n)) begin
			items_counted++;
		end
		sb.apply_item(m, r, c, pv);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.density_queue.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		sb.set_reg(idx, val);
		reg_writes++;
		@(posedge clk);
	endtask

	task automatic load_vector(logic [15:0] fixed, bit use_fixed);
		int unsigned n;
		n = sb.states_used();
		for (int r = 0; r < n; r++) begin
			send_item(mop_pkg::MODE_INIT, 3'(r), 3'($urandom_range(7)),
				use_fixed ? fixed : pick_prob());
		end
	endtask

	task automatic send_matrix();
		int unsigned n;
		int unsigned left;
		int unsigned v;
		bit stochastic;
		n = sb.states_used();
		stochastic = $urandom_range(1);
		for (int r = 0; r < n; r++) begin
			left = mop_pkg::ONE_Q15;
			for (int c = 0; c < n; c++) begin
				if (stochastic) begin
					v = (c == n - 1) ? left : $urandom_range(left);
					left -= v;
				end else begin
					v = pick_prob();
				end
				send_item(MODE_MATRIX, 3'(r), 3'(c), 16'(v));
			end
		end
	endtask

	task automatic send_partial();
		int unsigned n;
		int unsigned cnt;
		n = sb.states_used();
		cnt = $urandom_range(2 * n);
		repeat (cnt) begin
			send_item(MODE_MATRIX, 3'($urandom_range(n - 1)), 3'($urandom_range(n - 1)),
				pick_prob());
		end
		send_item(MODE_MATRIX, 3'(n - 1), 3'(n - 1), pick_prob());
	endtask

	// full vector, then one element repeated until its accumulator clips
	task automatic send_saturating();
		int unsigned n;
		logic [2:0] r;
		logic [2:0] c;
		n = sb.states_used();
		load_vector(mop_pkg::ONE_Q15, 1'b1);
		r = 3'($urandom_range(n - 2));
		c = 3'($urandom_range(n - 1));
		repeat (18) send_item(MODE_MATRIX, r, c, mop_pkg::ONE_Q15);
		send_item(MODE_MATRIX, 3'(n - 1), 3'(n - 1), pick_prob());
	endtask

	task automatic run_random(int unsigned count);
		int unsigned start;
		int unsigned pick;
		seq_kind_t kind;
		start = items_counted;
		while (items_counted - start < count) begin
			pick = $urandom_range(99);
			if (pick < 45) kind = SEQ_MATRIX;
			else if (pick < 60) kind = SEQ_LOAD;
			else if (pick < 72) kind = SEQ_PARTIAL;
			else if (pick < 78) kind = SEQ_SATURATE;
			else kind = SEQ_NOISE;
			case (kind)
				SEQ_MATRIX:   send_matrix();
				SEQ_LOAD:     load_vector('0, 1'b0);
				SEQ_PARTIAL:  send_partial();
				SEQ_SATURATE: send_saturating();
				default: send_item(1'($urandom_range(1)), 3'($urandom_range(7)),
					3'($urandom_range(7)), 16'($urandom_range(65535)));
			endcase
		end
	endtask

	initial begin
		logic [3:0]  phase_states [8];
		logic [31:0] phase_density [8];
		phase_states  = '{4'd2, 4'd8, 4'd3, 4'd15, 4'd5, 4'd0, 4'd7, 4'd1};
		phase_density = '{32'd0, 32'hFFFF_FFFF, 32'd65536, $urandom(),
			32'd1, $urandom(), 32'h8000_0000, $urandom()};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: full-size vector first so no entry is ever read unwritten
		write_reg(mop_pkg::REG_NUM_STATES, 32'd8);
		write_reg(mop_pkg::REG_DENSITY, 32'd65536);
		send_item(mop_pkg::MODE_INIT, 3'd0, 3'd7, 16'd0);
		send_item(mop_pkg::MODE_INIT, 3'd1, 3'd0, mop_pkg::ONE_Q15);
		send_item(mop_pkg::MODE_INIT, 3'd2, 3'd5, 16'hFFFF);
		send_item(mop_pkg::MODE_INIT, 3'd3, 3'd2, 16'd1);
		send_item(mop_pkg::MODE_INIT, 3'd4, 3'd7, 16'd16384);
		send_item(mop_pkg::MODE_INIT, 3'd5, 3'd1, 16'd32767);
		send_item(mop_pkg::MODE_INIT, 3'd6, 3'd3, 16'd12345);
		send_item(mop_pkg::MODE_INIT, 3'd7, 3'd6, 16'd20000);
		drain();
		write_reg(mop_pkg::REG_NUM_STATES, 32'd2);
		write_reg(mop_pkg::REG_DENSITY, 32'hFFFF_FFFF);
		// out of range, ignored
		send_item(mop_pkg::MODE_INIT, 3'd5, 3'd0, 16'd100);
		send_item(MODE_MATRIX, 3'd0, 3'd3, 16'd100);
		send_item(MODE_MATRIX, 3'd3, 3'd0, 16'd100);
		// complete matrix
		send_item(MODE_MATRIX, 3'd0, 3'd0, mop_pkg::ONE_Q15);
		send_item(MODE_MATRIX, 3'd0, 3'd1, 16'd0);
		send_item(MODE_MATRIX, 3'd1, 3'd0, 16'hFFFF);
		send_item(MODE_MATRIX, 3'd1, 3'd1, mop_pkg::ONE_Q15);
		// matrix that is only its last element
		send_item(MODE_MATRIX, 3'd1, 3'd1, 16'd16384);
		// repeated element accumulates twice
		send_item(MODE_MATRIX, 3'd0, 3'd1, mop_pkg::ONE_Q15);
		send_item(MODE_MATRIX, 3'd0, 3'd1, mop_pkg::ONE_Q15);
		send_item(MODE_MATRIX, 3'd1, 3'd1, 16'd0);
		// reload restarts the occasion count
		send_item(mop_pkg::MODE_INIT, 3'd0, 3'd7, 16'd0);
		send_item(mop_pkg::MODE_INIT, 3'd1, 3'd7, mop_pkg::ONE_Q15);

		for (int ph = 0; ph < 8; ph++) begin
			drain();
			case (ph % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 52; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 52; end
				default: begin send_idle_pct = 10; stall_pct = 10; end
			endcase
			write_reg(mop_pkg::REG_NUM_STATES, {28'd0, phase_states[ph]});
			write_reg(mop_pkg::REG_DENSITY, phase_density[ph]);
			run_random(ITEMS_PER_PHASE);
		end
		drain();

		$display("tb_top: %0d in-range items, %0d results checked, %0d register writes",
			items_counted, sb.results_checked, reg_writes);
		$display("tb_top: sizes 2 to 8 incl. clamped settings, highest occasion %0d",
			sb.top_occ);
		if (sb.mismatches == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: %0d mismatches", sb.mismatches);
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule
